// ===== hdl/pag_pkg.sv =====
`timescale 1ns / 1ps

package pag_pkg;

  // field widths
  localparam int unsigned SUM_W   = 26;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned SPP_W   = 11;

  // fixed-point format and divisor limit
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned FRAC_BITS   = 16;

  // scaling of the mean to 16 fractional bits ahead of the root
  localparam int unsigned ROOT_FRAC  = 2 * LEVEL_W;
  localparam int unsigned SHIFT_UP   = (FRAC_BITS < ROOT_FRAC) ? ROOT_FRAC - FRAC_BITS : 0;
  localparam int unsigned SHIFT_DOWN = (FRAC_BITS > ROOT_FRAC) ? FRAC_BITS - ROOT_FRAC : 0;
  localparam int unsigned MEAN_W     = SUM_W + SHIFT_UP;

  // pipeline shape: two quotient bits and two root bits per stage
  localparam int unsigned DIV_STAGES  = (SUM_W + 1) / 2;
  localparam int unsigned SQRT_STAGES = LEVEL_W / 2;
  localparam int unsigned LATENCY     = 1 + DIV_STAGES + SQRT_STAGES;

  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
  } pix_sum_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } pix_level_t;

endpackage

// ===== hdl/pag_chan.sv =====
`timescale 1ns / 1ps

module pag_chan #(
  parameter int unsigned FRAC_BITS = pag_pkg::FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic [pag_pkg::SUM_W-1:0]    sum_i,
  input  logic [pag_pkg::SPP_W-1:0]    div_i,
  output logic [pag_pkg::LEVEL_W-1:0]  level_o
);

  localparam int unsigned SW  = pag_pkg::SUM_W;
  localparam int unsigned DW  = pag_pkg::SPP_W;
  localparam int unsigned LW  = pag_pkg::LEVEL_W;
  localparam int unsigned VW  = 2 * LW;
  localparam int unsigned RW  = LW + 2;
  localparam int unsigned NDS = pag_pkg::DIV_STAGES;
  localparam int unsigned NSS = pag_pkg::SQRT_STAGES;

  // scaling of the mean to 16 fractional bits ahead of the root
  localparam int unsigned SHIFT_UP   = (FRAC_BITS < VW) ? VW - FRAC_BITS : 0;
  localparam int unsigned SHIFT_DOWN = (FRAC_BITS > VW) ? FRAC_BITS - VW : 0;
  localparam int unsigned MW         = SW + SHIFT_UP;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [SW-1:0] w;
  } div_st_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [LW-1:0] root;
    logic [VW-1:0] v;
  } sqrt_st_t;

  // one restoring division step: bring in the next dividend bit, shift in a quotient bit
  function automatic div_st_t div_step(div_st_t s, logic [DW-1:0] dv);
    logic [DW:0] t;
    div_st_t     r;
    t   = {s.rem, s.w[SW-1]};
    r.w = {s.w[SW-2:0], 1'b0};
    if (t >= {1'b0, dv}) begin
      t      = t - {1'b0, dv};
      r.w[0] = 1'b1;
    end
    r.rem = t[DW-1:0];
    return r;
  endfunction

  // one digit-by-digit square root step on two radicand bits
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    sqrt_st_t      r;
    t     = {s.rem, s.v[VW-1:VW-2]};
    trial = {2'b00, s.root, 2'b01};
    r.v   = {s.v[VW-3:0], 2'b00};
    if (t >= trial) begin
      t      = t - trial;
      r.root = {s.root[LW-2:0], 1'b1};
    end else begin
      r.root = {s.root[LW-2:0], 1'b0};
    end
    r.rem = t[RW-1:0];
    return r;
  endfunction

  div_st_t       div_q [NDS+1];
  logic [DW-1:0] dv_q  [NDS+1];
  sqrt_st_t      sq_q  [NSS];
  logic          sat_q [NSS];

  // input capture
  always_ff @(posedge clk_i) begin
    div_q[0].rem <= '0;
    div_q[0].w   <= sum_i;
    dv_q[0]      <= div_i;
  end

  // divider stages
  for (genvar k = 1; k <= NDS; k++) begin : g_div
    div_st_t step_a;
    div_st_t step_b;

    assign step_a = div_step(div_q[k-1], dv_q[k-1]);
    assign step_b = div_step(step_a, dv_q[k-1]);

    always_ff @(posedge clk_i) begin
      div_q[k] <= step_b;
      dv_q[k]  <= dv_q[k-1];
    end
  end

  // rescale the mean to 16 fractional bits and flag a root of 256 or more
  logic [MW-1:0] mean_w;
  logic          mean_sat;
  sqrt_st_t      sq_in;

  assign mean_w   = (MW'(div_q[NDS].w) << SHIFT_UP) >> SHIFT_DOWN;
  assign mean_sat = |mean_w[MW-1:VW];
  assign sq_in    = '{rem: '0, root: '0, v: mean_w[VW-1:0]};

  // square root stages
  for (genvar j = 0; j < NSS; j++) begin : g_sqrt
    sqrt_st_t src;
    sqrt_st_t step_a;
    sqrt_st_t step_b;
    logic     sat_src;

    if (j == 0) begin : g_first
      assign src     = sq_in;
      assign sat_src = mean_sat;
    end else begin : g_next
      assign src     = sq_q[j-1];
      assign sat_src = sat_q[j-1];
    end

    assign step_a = sqrt_step(src);
    assign step_b = sqrt_step(step_a);

    always_ff @(posedge clk_i) begin
      sq_q[j]  <= step_b;
      sat_q[j] <= sat_src;
    end
  end

  // saturate bright channels at full scale
  assign level_o = sat_q[NSS-1] ? {LW{1'b1}} : sq_q[NSS-1].root;

endmodule

// ===== hdl/pixel_average_gamma_quantize_unit.sv =====
`timescale 1ns / 1ps
// a transaction's result passes the input register, divider and root stages to done_o
// throughput: one pixel per cycle; busy is always low and the receiver cannot stall
// depth is set by the restoring divider (two quotient bits per stage, 13 stages)
// plus four square root stages (two root bits per stage) and one input register
// reset clears the valid pipeline and sets the sample count to 1
module pixel_average_gamma_quantize_unit #(
  parameter int unsigned MAX_SAMPLES = pag_pkg::MAX_SAMPLES,
  parameter int unsigned FRAC_BITS   = pag_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pag_pkg::pix_sum_t           sums_i,
  output logic                        done_o,
  output pag_pkg::pix_level_t         levels_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pag_pkg::SPP_W-1:0]   cfg_data_i
);

  localparam int unsigned DW  = pag_pkg::SPP_W;
  localparam int unsigned LAT = pag_pkg::LATENCY;

  logic [DW-1:0]  spp_q;
  logic [DW-1:0]  div_eff;
  logic [LAT-1:0] vld_q;
  logic           accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // sample count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= DW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      spp_q <= cfg_data_i;
    end
  end

  // effective divisor: zero counts as one, large counts clamp
  always_comb begin
    if (spp_q == '0) begin
      div_eff = DW'(1);
    end else if (32'(spp_q) > MAX_SAMPLES) begin
      div_eff = DW'(MAX_SAMPLES);
    end else begin
      div_eff = spp_q;
    end
  end

  // valid bits travel alongside the channel pipelines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  assign done_o = vld_q[LAT-1];

  // channel datapaths
  pag_chan #(
    .FRAC_BITS (FRAC_BITS)
  ) u_red (
    .clk_i   (clk_i),
    .sum_i   (sums_i.red_sum),
    .div_i   (div_eff),
    .level_o (levels_o.red_level)
  );

  pag_chan #(
    .FRAC_BITS (FRAC_BITS)
  ) u_green (
    .clk_i   (clk_i),
    .sum_i   (sums_i.green_sum),
    .div_i   (div_eff),
    .level_o (levels_o.green_level)
  );

  pag_chan #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blue (
    .clk_i   (clk_i),
    .sum_i   (sums_i.blue_sum),
    .div_i   (div_eff),
    .level_o (levels_o.blue_level)
  );

  // every result traces back to a transaction accepted at the head of the valid pipeline
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result without matching transaction");

  // divisor always in the legal range
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_eff != '0 && 32'(div_eff) <= MAX_SAMPLES)
    else $error("effective divisor out of range");

  // a written sample count takes effect at the next edge
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> spp_q == $past(cfg_data_i))
    else $error("sample count write lost");

  // a black channel stays black through divider and root
  a_zero_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(accept && sums_i.red_sum == '0, LAT)) |-> levels_o.red_level == '0)
    else $error("zero red sum gave nonzero level");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [pag_pkg::SUM_W-1:0] SUM_MAX = '1;
  localparam logic [pag_pkg::LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned PHASE_COUNT = 12;

  // one row of the directed stimulus table
  typedef struct packed {
    logic                      set_spp;
    logic [pag_pkg::SPP_W-1:0] spp;
    pag_pkg::pix_sum_t         sums;
    logic                      typed;
    pag_pkg::pix_level_t       want;
  } pixel_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  pag_pkg::pix_sum_t         sums_i;
  logic                      done_o;
  pag_pkg::pix_level_t       levels_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [pag_pkg::SPP_W-1:0] cfg_data_i;

  pag_pkg::pix_level_t       level_q[$];
  pag_pkg::pix_level_t       oldest_level;
  pixel_row_t                pixel_plan[$];
  logic [pag_pkg::SPP_W-1:0] spp_now;
  int unsigned               err_count = 0;
  int unsigned               cycle_count = 0;
  bit                        no_idle;
  int spp_plan[PHASE_COUNT] = '{1, 2, 3, 5, 16, 100, 1023, 1024, 1025, 2047, 0, -1};

  pixel_average_gamma_quantize_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .sums_i      (sums_i),
    .done_o      (done_o),
    .levels_o    (levels_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // divisor after the zero and saturation rules
  function automatic longint unsigned eff_count(input logic [pag_pkg::SPP_W-1:0] n);
    longint unsigned c;
    c = (n == 0) ? 1 : n;
    if (c > pag_pkg::MAX_SAMPLES) c = pag_pkg::MAX_SAMPLES;
    return c;
  endfunction

  // floor mean, rescale to 16 fractional bits, integer root, saturate
  function automatic logic [pag_pkg::LEVEL_W-1:0] channel_level(
      input logic [pag_pkg::SUM_W-1:0] s,
      input logic [pag_pkg::SPP_W-1:0] n);
    longint unsigned mean;
    longint unsigned v;
    longint unsigned t;
    logic [pag_pkg::LEVEL_W-1:0] root;
    mean = longint'(s) / eff_count(n);
    v = (mean << pag_pkg::SHIFT_UP) >> pag_pkg::SHIFT_DOWN;
    if (v >= (64'd1 << pag_pkg::ROOT_FRAC)) return LEVEL_MAX;
    root = '0;
    for (int b = pag_pkg::LEVEL_W - 1; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= v) root = t[pag_pkg::LEVEL_W-1:0];
    end
    return root;
  endfunction

  function automatic pag_pkg::pix_level_t pixel_levels(input pag_pkg::pix_sum_t s);
    pag_pkg::pix_level_t lv;
    lv.red_level   = channel_level(s.red_sum, spp_now);
    lv.green_level = channel_level(s.green_sum, spp_now);
    lv.blue_level  = channel_level(s.blue_sum, spp_now);
    return lv;
  endfunction

  // channel sum aimed at zero, full scale, small means, the bright edge or a random value
  function automatic logic [pag_pkg::SUM_W-1:0] pick_sum();
    longint unsigned c;
    longint unsigned v;
    logic [31:0] r;
    c = eff_count(spp_now);
    r = $urandom();
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = SUM_MAX;
      2: v = $urandom_range(0, 300) * c + $urandom_range(0, c - 1);
      3: v = c * 65536 + $urandom_range(0, 2 * c) - c;
      default: v = r[pag_pkg::SUM_W-1:0];
    endcase
    if (v > SUM_MAX) v = SUM_MAX;
    return v[pag_pkg::SUM_W-1:0];
  endfunction

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // one pixel transaction, then the sender's idle gap, if any
  task automatic send_pixel(input pag_pkg::pix_sum_t s, input logic typed,
                            input pag_pkg::pix_level_t lv);
    pag_pkg::pix_level_t want;
    int unsigned gap;
    want = typed ? lv : pixel_levels(s);
    start  <= 1'b1;
    sums_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    level_q.push_back(want);
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every pending level has come out
  task automatic settle_pipeline();
    start <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (pag_pkg::LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_spp(input logic [pag_pkg::SPP_W-1:0] v);
    settle_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    spp_now = v;
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (level_q.size() == 0) begin
        report("result with no pending transaction");
      end else begin
        oldest_level = level_q.pop_front();
        if (levels_o.red_level !== oldest_level.red_level)
          report($sformatf("red got %0d want %0d",
                           levels_o.red_level, oldest_level.red_level));
        if (levels_o.green_level !== oldest_level.green_level)
          report($sformatf("green got %0d want %0d",
                           levels_o.green_level, oldest_level.green_level));
        if (levels_o.blue_level !== oldest_level.blue_level)
          report($sformatf("blue got %0d want %0d",
                           levels_o.blue_level, oldest_level.blue_level));
      end
    end
  end

  // stimulus
  initial begin
    pag_pkg::pix_sum_t s;
    rst_ni      = 1'b0;
    start       = 1'b0;
    sums_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    spp_now     = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset count, zero count, saturated count, extremes
    pixel_plan.push_back({1'b0, 11'd0, {26'd0, 26'd0, 26'd0}, 1'b1, {8'd0, 8'd0, 8'd0}});
    pixel_plan.push_back({1'b0, 11'd0, {SUM_MAX, SUM_MAX, SUM_MAX}, 1'b1,
                          {LEVEL_MAX, LEVEL_MAX, LEVEL_MAX}});
    pixel_plan.push_back({1'b0, 11'd0, {26'd65535, 26'd65536, 26'd1}, 1'b1,
                          {8'd255, 8'd255, 8'd1}});
    pixel_plan.push_back({1'b0, 11'd0, {26'd4, 26'd3, 26'd2}, 1'b1, {8'd2, 8'd1, 8'd1}});
    pixel_plan.push_back({1'b0, 11'd0, {26'd16384, 26'd16383, 26'd0}, 1'b1,
                          {8'd128, 8'd127, 8'd0}});
    pixel_plan.push_back({1'b0, 11'd0, {26'd1000000, 26'd123456, 26'd7777777}, 1'b0, 24'd0});
    pixel_plan.push_back({1'b1, 11'd0, {26'd4, 26'd65536, 26'd0}, 1'b1,
                          {8'd2, 8'd255, 8'd0}});
    pixel_plan.push_back({1'b1, 11'd2047, {SUM_MAX, 26'd67107840, 26'd1023}, 1'b1,
                          {8'd255, 8'd255, 8'd0}});
    pixel_plan.push_back({1'b0, 11'd0, {26'd30000000, 26'd5000000, 26'd1048576}, 1'b0, 24'd0});
    pixel_plan.push_back({1'b1, 11'd1024, {SUM_MAX, 26'd67107840, 26'd4096}, 1'b1,
                          {8'd255, 8'd255, 8'd2}});
    pixel_plan.push_back({1'b1, 11'd1025, {26'd4096, 26'd4095, 26'd0}, 1'b1,
                          {8'd2, 8'd1, 8'd0}});
    pixel_plan.push_back({1'b1, 11'd3, {26'd196608, 26'd196607, 26'd5}, 1'b1,
                          {8'd255, 8'd255, 8'd1}});
    pixel_plan.push_back({1'b0, 11'd0, {26'd1234567, 26'd9999999, 26'd42}, 1'b0, 24'd0});
    pixel_plan.push_back({1'b1, 11'd2, {SUM_MAX, 26'd131071, 26'd131072}, 1'b0, 24'd0});
    foreach (pixel_plan[i]) begin
      if (pixel_plan[i].set_spp) write_spp(pixel_plan[i].spp);
      send_pixel(pixel_plan[i].sums, pixel_plan[i].typed, pixel_plan[i].want);
    end

    // random phases, one sample count each
    foreach (spp_plan[p]) begin
      write_spp((spp_plan[p] < 0) ? pag_pkg::SPP_W'($urandom_range(0, 2047))
                                  : pag_pkg::SPP_W'(spp_plan[p]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 10 == 0) no_idle = ($urandom_range(0, 2) == 0);
        s.red_sum   = pick_sum();
        s.green_sum = pick_sum();
        s.blue_sum  = pick_sum();
        send_pixel(s, 1'b0, 24'd0);
        if ($urandom_range(0, 39) == 0) settle_pipeline();
      end
    end

    settle_pipeline();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pag_pkg.sv
hdl/pag_chan.sv
hdl/pixel_average_gamma_quantize_unit.sv
tb/testbench.sv
